FILE: sv/rgbpwm_pkg.sv
`default_nettype none

package rgbpwm_pkg;

    // Widths fixed by the item and register formats.
    localparam int DUTY_W   = 8;
    localparam int CHAN_W   = 8;
    localparam int INDEX_W  = 8;
    localparam int FRAME_W  = 9;
    localparam int COLOUR_W = 3 * CHAN_W;

    // Beats per slot and the counter that walks them.
    localparam int SLOT_BEATS = 24;
    localparam int BEAT_W     = 5;
    localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(SLOT_BEATS - 1);

    // Store default for one entry, packed green, red, blue from the top bit down.
    localparam logic [COLOUR_W-1:0] STORE_RESET = {8'h00, 8'h00, 8'hFF};

    // Register reset values.
    localparam logic [DUTY_W-1:0]  HIGH_DUTY_RESET    = 8'd49;
    localparam logic [DUTY_W-1:0]  LOW_DUTY_RESET     = 8'd20;
    localparam logic [FRAME_W-1:0] FRAME_PIXELS_RESET = 9'd256;

    localparam int PIXELS_DEFAULT = 256;

    // Register indexes on the configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_DUTY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_DUTY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS = 2'd2;

    // Kinds of input beat.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SLOT  = 1'b1;

    typedef struct packed {
        logic [DUTY_W-1:0] high;
        logic [DUTY_W-1:0] low;
    } t_duty;

    typedef struct packed {
        logic                gap;
        logic [COLOUR_W-1:0] bits;
    } t_slot;

endpackage

`default_nettype wire

FILE: sv/rgb_pixel_to_pwm_duty_slots.sv
`default_nettype none

// Pixel store and duty slot encoder for a single-wire RGB LED chain. Input
// beats are of two kinds, told apart by s_axis_tuser: a pixel write stores a
// colour at its index and gives no output, and a slot request gives 24 output
// beats of timer duty values, the last one marked with m_axis_tlast. While a
// frame runs, each slot carries the pixel at the frame position in green, red,
// blue order, most significant bit first; a one bit gives high_duty and a zero
// bit low_duty. When the position reaches the frame length (frame_pixels,
// capped at PIXELS) a slot of zero duties is given, the position rewinds and a
// gap flag is raised, so that the next request gives a second zero slot. The
// store is a single synchronous RAM; after reset a clearing pass writes the
// default colour (blue at full, red and green off) to all PIXELS entries, one
// per cycle, and no input beat is accepted during the clearing pass. Pixel
// writes can then be taken every cycle. A slot request is read from the RAM in
// the cycle it is accepted and is handed to the output serialiser, which
// emits one beat per cycle while the output is not stalled, and a new request
// is accepted while the previous slot is still leaving. Writes beyond the
// store are dropped. Configuration is taken on any cycle with i_cfg_we high
// and should only be changed while no slot is in flight.
module rgb_pixel_to_pwm_duty_slots
    import rgbpwm_pkg::*;
#(
    parameter int PIXELS = PIXELS_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write port.
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [FRAME_W-1:0]   i_cfg_data,
    // Input stream.
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [7:0] pixel_index, [15:8] red_value, [23:16] green_value, [31:24] blue_value
    input  wire logic [31:0]          s_axis_tdata,
    // [0] req_type
    input  wire logic                 s_axis_tuser,
    // Output stream.
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [7:0] duty_value
    output logic      [DUTY_W-1:0]    m_axis_tdata,
    // last_of_slot
    output logic                      m_axis_tlast
);

    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);

    // Configuration registers.
    logic [DUTY_W-1:0]  r_high_duty;
    logic [DUTY_W-1:0]  r_low_duty;
    logic [FRAME_W-1:0] r_frame_pixels;

    // Frame control state.
    logic [FRAME_W-1:0] r_pos;
    logic               r_gap;
    logic               r_slot_valid;
    logic               r_slot_gap;

    // Clearing pass.
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;

    logic                w_acc;
    logic                w_wr;
    logic                w_req;
    logic                w_idx_ok;
    logic                w_at_end;
    logic                w_slot_take;
    logic                w_ram_we;
    logic [AW-1:0]       w_ram_waddr;
    logic [COLOUR_W-1:0] w_ram_wdata;
    logic                w_ram_re;
    logic [COLOUR_W-1:0] w_ram_rdata;
    t_slot               w_slot;
    t_duty               w_duty;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_duty    <= HIGH_DUTY_RESET;
            r_low_duty     <= LOW_DUTY_RESET;
            r_frame_pixels <= FRAME_PIXELS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HIGH_DUTY:    r_high_duty    <= i_cfg_data[DUTY_W-1:0];
                CFG_LOW_DUTY:     r_low_duty     <= i_cfg_data[DUTY_W-1:0];
                CFG_FRAME_PIXELS: r_frame_pixels <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input handshake. A pixel write can always be taken once the store is
    // cleared; a slot request needs the hand-over slot to the serialiser free.
    // ------------------------------------------------------------------
    assign s_axis_tready = !r_clr_busy
                           && ((s_axis_tuser == REQ_WRITE) || !r_slot_valid);
    assign w_acc    = s_axis_tvalid && s_axis_tready;
    assign w_wr     = w_acc && (s_axis_tuser == REQ_WRITE);
    assign w_req    = w_acc && (s_axis_tuser == REQ_SLOT);
    assign w_idx_ok = (32'(s_axis_tdata[7:0]) < 32'(PIXELS));

    // The frame is over once the position reaches the programmed length or
    // the end of the store, whichever is shorter. A length shortened below
    // the current position also ends the frame.
    assign w_at_end = (r_pos >= r_frame_pixels) || (32'(r_pos) >= 32'(PIXELS));

    // ------------------------------------------------------------------
    // Pixel store. The clearing pass owns the write port after reset. Reads
    // and writes come from different beats, so a read always sees every
    // write accepted before it and no forwarding is needed.
    // ------------------------------------------------------------------
    assign w_ram_we    = r_clr_busy || (w_wr && w_idx_ok);
    assign w_ram_waddr = r_clr_busy ? r_clr_addr : AW'(s_axis_tdata[7:0]);
    assign w_ram_wdata = r_clr_busy ? STORE_RESET
                                    : {s_axis_tdata[23:16], s_axis_tdata[15:8],
                                       s_axis_tdata[31:24]};
    assign w_ram_re    = w_req && !r_gap && !w_at_end;

    rgbpwm_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (AW'(r_pos)),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Frame position and gap flag, updated as a request is accepted. The
    // hand-over flag marks a slot whose colour sits on the RAM read port.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_gap        <= 1'b0;
            r_slot_valid <= 1'b0;
        end else begin
            if (w_req) begin
                if (r_gap) begin
                    r_gap <= 1'b0;
                end else if (w_at_end) begin
                    r_gap <= 1'b1;
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + FRAME_W'(1);
                end
            end
            if (w_req) begin
                r_slot_valid <= 1'b1;
            end else if (w_slot_take) begin
                r_slot_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req) begin
            r_slot_gap <= r_gap || w_at_end;
        end
    end

    // ------------------------------------------------------------------
    // Output serialiser.
    // ------------------------------------------------------------------
    assign w_slot.gap  = r_slot_gap;
    assign w_slot.bits = w_ram_rdata;
    assign w_duty.high = r_high_duty;
    assign w_duty.low  = r_low_duty;

    rgbpwm_ser u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_slot_valid (r_slot_valid),
        .i_slot       (w_slot),
        .i_duty       (w_duty),
        .o_slot_take  (w_slot_take),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata),
        .o_tlast      (m_axis_tlast)
    );

    a_gap_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap |-> (r_pos == '0))
        else $error("gap pending while the frame position is not rewound");

    a_req_fills_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req |=> r_slot_valid)
        else $error("accepted request left no slot for the serialiser");

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!w_acc && !w_ram_re))
        else $error("input beat taken during the clearing pass");

endmodule

`default_nettype wire

FILE: sv/rgbpwm_ram.sv
`default_nettype none

module rgbpwm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/rgbpwm_ser.sv
`default_nettype none

module rgbpwm_ser
    import rgbpwm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_slot_valid,
    input  wire t_slot             i_slot,
    input  wire t_duty             i_duty,
    output logic                   o_slot_take,
    output logic                   o_tvalid,
    input  wire logic              i_tready,
    output logic      [DUTY_W-1:0] o_tdata,
    output logic                   o_tlast
);

    logic                r_valid;
    logic [BEAT_W-1:0]   r_cnt;
    logic [COLOUR_W-1:0] r_bits;
    logic                r_gap;
    logic                w_fire;
    logic                w_end;

    assign w_fire      = r_valid && i_tready;
    assign w_end       = w_fire && (r_cnt == LAST_BEAT);
    assign o_slot_take = i_slot_valid && (!r_valid || w_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (o_slot_take) begin
            r_valid <= 1'b1;
            r_cnt   <= '0;
        end else if (w_end) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (w_fire) begin
            r_cnt <= r_cnt + BEAT_W'(1);
        end
    end

    // The colour word leaves most significant bit first.
    always_ff @(posedge i_clk) begin
        if (o_slot_take) begin
            r_bits <= i_slot.bits;
            r_gap  <= i_slot.gap;
        end else if (w_fire) begin
            r_bits <= {r_bits[COLOUR_W-2:0], 1'b0};
        end
    end

    assign o_tvalid = r_valid;
    assign o_tlast  = (r_cnt == LAST_BEAT);
    assign o_tdata  = r_gap ? '0 : (r_bits[COLOUR_W-1] ? i_duty.high : i_duty.low);

    a_idle_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> (r_cnt == '0))
        else $error("beat counter not at zero while idle");

    a_take_starts_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_slot_take |=> (r_valid && (r_cnt == '0)))
        else $error("slot taken but serialiser did not start at its first beat");

    a_mid_slot_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_cnt != LAST_BEAT)) |=> r_valid)
        else $error("slot ended before its last beat");

endmodule

`default_nettype wire

FILE: dv/rgbpwm_duty_checker.sv
module rgbpwm_duty_checker
    import rgbpwm_pkg::*;
#(
    parameter int PIXELS = PIXELS_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [FRAME_W-1:0]   i_cfg_data,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    // [7:0] pixel_index, [15:8] red_value, [23:16] green_value, [31:24] blue_value
    input  wire logic [31:0]          s_axis_tdata,
    // [0] req_type
    input  wire logic                 s_axis_tuser,
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [7:0] duty_value
    input  wire logic [DUTY_W-1:0]    m_axis_tdata,
    input  wire logic                 m_axis_tlast,
    output int                        o_fail_count,
    output int                        o_pending_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              last;
    } t_duty_beat;

    // Each entry is packed green, red, blue from the top bit down, which is
    // exactly the order in which a slot sends its bits.
    logic [COLOUR_W-1:0] colour_store [PIXELS];
    logic [FRAME_W-1:0]  model_pos;
    logic [FRAME_W-1:0]  frame_len;
    logic                gap_flag;
    t_duty               duty_regs;
    t_duty_beat          duty_q [$];

    initial o_fail_count = 0;
    initial o_pending_beats = 0;

    task reset_model();
        foreach (colour_store[i]) begin
            colour_store[i] = STORE_RESET;
        end
        model_pos      = '0;
        gap_flag       = 1'b0;
        duty_regs.high = HIGH_DUTY_RESET;
        duty_regs.low  = LOW_DUTY_RESET;
        frame_len      = FRAME_PIXELS_RESET;
        duty_q.delete();
    endtask

    // Works out the 24 duty beats of one slot request and queues them.
    task queue_slot();
        int                  limit;
        int                  k;
        logic                gap;
        logic [COLOUR_W-1:0] bits;
        t_duty_beat          beat;
        limit = (int'(frame_len) > PIXELS) ? PIXELS : int'(frame_len);
        gap   = 1'b1;
        bits  = '0;
        if (gap_flag) begin
            gap_flag = 1'b0;
        end else if (int'(model_pos) >= limit) begin
            gap_flag  = 1'b1;
            model_pos = '0;
        end else begin
            bits      = colour_store[AW'(model_pos)];
            model_pos = model_pos + FRAME_W'(1);
            gap       = 1'b0;
        end
        for (k = 0; k < SLOT_BEATS; k++) begin
            if (gap) begin
                beat.duty = '0;
            end else begin
                beat.duty = bits[COLOUR_W-1] ? duty_regs.high : duty_regs.low;
            end
            bits      = {bits[COLOUR_W-2:0], 1'b0};
            beat.last = (k == SLOT_BEATS - 1);
            duty_q.push_back(beat);
        end
    endtask

    task check_beat();
        t_duty_beat want;
        if (duty_q.size() == 0) begin
            $error("unexpected duty beat: duty_value %0d, last_of_slot %0b",
                   m_axis_tdata, m_axis_tlast);
            o_fail_count++;
        end else begin
            want = duty_q.pop_front();
            if (m_axis_tdata !== want.duty) begin
                $error("duty_value mismatch: expected %0d, actual %0d",
                       want.duty, m_axis_tdata);
                o_fail_count++;
            end
            if (m_axis_tlast !== want.last) begin
                $error("last_of_slot mismatch: expected %0b, actual %0b",
                       want.last, m_axis_tlast);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            // Outputs first, so that a beat leaving in the same cycle as a new
            // request is matched against the older expectations.
            if (m_axis_tvalid && m_axis_tready) begin
                check_beat();
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HIGH_DUTY: begin
                        duty_regs.high = i_cfg_data[DUTY_W-1:0];
                    end
                    CFG_LOW_DUTY: begin
                        duty_regs.low = i_cfg_data[DUTY_W-1:0];
                    end
                    CFG_FRAME_PIXELS: begin
                        frame_len = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == REQ_WRITE) begin
                    if (int'(s_axis_tdata[7:0]) < PIXELS) begin
                        colour_store[AW'(s_axis_tdata[7:0])] =
                            {s_axis_tdata[23:16], s_axis_tdata[15:8], s_axis_tdata[31:24]};
                    end
                end else begin
                    queue_slot();
                end
            end
        end
        o_pending_beats <= duty_q.size();
    end

endmodule

FILE: dv/rgb_pixel_to_pwm_duty_slots_test.sv
module rgb_pixel_to_pwm_duty_slots_test;
    import rgbpwm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The fourth register index is not decoded by the block; writes to it
    // must leave every register untouched.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [FRAME_W-1:0]   i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DUTY_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;

    int fail_count;
    int pending_beats;

    // Percentages of cycles in which the sender holds back and in which the
    // receiver refuses a beat. Later phases of the run change them.
    int idle_pct  = 0;
    int stall_pct = 0;

    rgb_pixel_to_pwm_duty_slots u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // The checker sees exactly what the block sees, keeps its own copy of the
    // pixel store, frame position, gap flag and registers, and compares every
    // output beat with the oldest predicted one.
    rgbpwm_duty_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending_beats (pending_beats)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The receiver decides afresh on every edge whether it takes a beat, so
    // stalls land on every position within a slot.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // One register write per clock edge. The write enable is left high so that
    // back-to-back writes never lower and raise it in the same step; the caller
    // drops it once the sequence is over.
    task write_reg(input logic [CFG_IDX_W-1:0] index, input logic [FRAME_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Writes all three registers and then a stray write to the undecoded
    // index. The spare top data bit of the duty registers is randomised, as
    // only the low eight bits may be taken.
    task program_regs(input logic [DUTY_W-1:0] high, input logic [DUTY_W-1:0] low,
                      input logic [FRAME_W-1:0] frame);
        logic [FRAME_W-1:0] stray;
        stray = FRAME_W'($urandom_range(0, 511));
        write_reg(CFG_HIGH_DUTY, {($urandom_range(0, 1) == 1), high});
        write_reg(CFG_LOW_DUTY, {($urandom_range(0, 1) == 1), low});
        write_reg(CFG_FRAME_PIXELS, frame);
        write_reg(CFG_UNUSED, stray);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one input beat and returns at the edge that accepts it. Before the
    // beat the sender may hold back, one coin toss per cycle.
    task send_beat(input logic kind, input logic [31:0] payload);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= payload;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stops offering beats and waits until every predicted duty beat has come
    // out, then lets a margin pass so that a pixel write still in the pipe has
    // landed in the store before any register changes.
    task wait_drained(input int margin);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_beats != 0);
        repeat (margin) @(posedge i_clk);
    endtask

    // Colour bytes lean towards all zeros and all ones, so that whole slots
    // of one duty value turn up often next to mixed ones.
    function automatic logic [CHAN_W-1:0] rand_channel();
        logic [CHAN_W-1:0] v;
        v = CHAN_W'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            default: begin
            end
        endcase
        return v;
    endfunction

    // A random mix of slot requests and pixel writes. Slot requests carry
    // random data in the unused payload so that it is seen to be ignored.
    task run_random(input int count, input int slot_pct);
        int                 n;
        logic [INDEX_W-1:0] index;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < slot_pct) begin
                send_beat(REQ_SLOT, $urandom());
            end else begin
                index = INDEX_W'($urandom_range(0, 255));
                red   = rand_channel();
                green = rand_channel();
                blue  = rand_channel();
                send_beat(REQ_WRITE, {blue, green, red, index});
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset register values and no idling on either side.
        // The first two slots read untouched entries and so carry the default
        // colour: sixteen low duties then eight high ones.
        send_beat(REQ_SLOT, 32'h0);
        send_beat(REQ_SLOT, 32'hFFFF_FFFF);
        // Last entry: red full, green off, blue 0xA5.
        send_beat(REQ_WRITE, {8'hA5, 8'h00, 8'hFF, 8'hFF});
        // First entry: red off, green full, blue 0x5A.
        send_beat(REQ_WRITE, {8'h5A, 8'hFF, 8'h00, 8'h00});
        // Entry 2, read by the very next beat straight after being written.
        send_beat(REQ_WRITE, {8'h7F, 8'h01, 8'h80, 8'h02});
        send_beat(REQ_SLOT, 32'h0);
        wait_drained(16);

        // The frame is cut to three pixels while the position already stands
        // at three, so the next request counts as the end of the frame: two
        // gap slots, then the frame restarts at the first pixel.
        program_regs(8'hFF, 8'h00, 9'd3);
        repeat (4) send_beat(REQ_SLOT, 32'h0);
        wait_drained(16);

        // An empty frame gives nothing but gap slots. Duties are swapped to
        // their opposite extremes.
        program_regs(8'h00, 8'hFF, 9'd0);
        repeat (3) send_beat(REQ_SLOT, 32'h0);
        wait_drained(16);

        // A one-pixel frame, entered with the gap flag still raised.
        program_regs(8'hAA, 8'h55, 9'd1);
        repeat (3) send_beat(REQ_SLOT, 32'h0);
        wait_drained(16);

        // Random part. The first two phases together take the frame position
        // once right round the store, the wrap itself happening while the
        // frame length is set beyond the store size.
        program_regs(DUTY_W'($urandom_range(0, 255)), DUTY_W'($urandom_range(0, 255)),
                     9'd256);
        run_random(140, 88);
        wait_drained(16);

        idle_pct = 47;
        program_regs(DUTY_W'($urandom_range(0, 255)), DUTY_W'($urandom_range(0, 255)),
                     9'd511);
        run_random(180, 88);
        wait_drained(16);

        // Short frames from here on, entered with the position far beyond
        // their end, with the receiver stalling.
        idle_pct  = 0;
        stall_pct = 47;
        program_regs(DUTY_W'($urandom_range(0, 255)), DUTY_W'($urandom_range(0, 255)),
                     FRAME_W'($urandom_range(1, 6)));
        run_random(40, 60);
        wait_drained(16);

        // Both sides idle. Halfway through the sender pauses until the output
        // has fully drained before it carries on.
        idle_pct  = 34;
        stall_pct = 34;
        program_regs(DUTY_W'($urandom_range(0, 255)), DUTY_W'($urandom_range(0, 255)),
                     FRAME_W'($urandom_range(2, 12)));
        run_random(20, 70);
        wait_drained(0);
        run_random(20, 70);

        wait_drained(32);
        if (fail_count == 0) begin
            $display("rgb_pixel_to_pwm_duty_slots regression: pass");
        end else begin
            $display("rgb_pixel_to_pwm_duty_slots regression: fail");
        end
        $finish;
    end

    // The time limit is many times the slowest correct run, including the
    // clearing pass of the store after reset.
    initial begin
        #5_000_000;
        $display("rgb_pixel_to_pwm_duty_slots regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
sv/rgbpwm_pkg.sv
sv/rgbpwm_ram.sv
sv/rgbpwm_ser.sv
sv/rgb_pixel_to_pwm_duty_slots.sv
dv/rgbpwm_duty_checker.sv
dv/rgb_pixel_to_pwm_duty_slots_test.sv
